/* rtl/assert_macros.svh */
// assertion helpers for the sha-1 digest core checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHA1MD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1md check failed");

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1md check failed");

`endif

/* rtl/sha1md_pkg.sv */
package sha1md_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic {
    OP_ABSORB,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  push_word;
    word_t word;
    logic  start;
    logic  step;
    logic  fold;
    logic  restart;
    logic  sha1;
  } round_ctl_t;

  typedef struct packed {
    logic last;
  } round_sts_t;

  localparam int DIGEST_WORDS = 5;
  localparam int LINE_WORDS   = 16;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_B1   = 7'd20;
  localparam logic [6:0] ROUND_B2   = 7'd40;
  localparam logic [6:0] ROUND_B3   = 7'd60;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t INIT_H [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'h3F;
  localparam logic [2:0] LAST_IDX = 3'd4;

endpackage

/* rtl/sha1md_if.sv */
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

interface sha1md_cfg_if;
  logic valid;
  logic ready;
  logic rotate_schedule;
  modport source (output valid, rotate_schedule, input ready);
  modport sink (input valid, rotate_schedule, output ready);
endinterface

/* rtl/sha1_message_digest_core.sv */
// SHA-1 / SHA-0 digest core, fed one message byte per request. A small input queue takes
// requests while the engine works. Every 64th absorbed byte starts a compression: 80
// rounds of the single round unit, then the chaining add. A finish request pads one byte
// per cycle up to the length field, except while a full block is being compressed, runs
// one or two compressions, then presents the five digest words, one per cycle while
// out_rsp.ready is high, with last on word 4; the engine then returns to the initial
// chaining values. rotate_schedule (reset 1) selects SHA-1, 0 selects SHA-0; write it
// only while the core is idle.
module sha1_message_digest_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  sha1md_in_if.sink    in_req,
  sha1md_out_if.source out_rsp,
  sha1md_cfg_if.sink   cfg_wr
);
  import sha1md_pkg::*;

  head_t      head;
  logic       pop;
  round_ctl_t rctl;
  round_sts_t rsts;
  word_t      chain [DIGEST_WORDS];

  sha1md_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_req(in_req),
    .head  (head),
    .pop   (pop)
  );

  sha1md_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .cfg_wr (cfg_wr),
    .out_rsp(out_rsp),
    .rctl   (rctl),
    .rsts   (rsts),
    .chain  (chain)
  );

  sha1md_round u_round (
    .clk  (clk),
    .rst_n(rst_n),
    .rctl (rctl),
    .rsts (rsts),
    .chain(chain)
  );

endmodule

/* rtl/sha1md_front.sv */
module sha1md_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  sha1md_in_if.sink       in_req,
  output sha1md_pkg::head_t head,
  input  logic            pop
);
  import sha1md_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  item_t            in_item;

  // classify the request
  always_comb begin
    in_item.op   = in_req.action ? OP_FINISH : OP_ABSORB;
    in_item.data = in_req.data_byte;
  end

  assign in_req.ready = (cnt_r != CNT_FULL);
  assign push         = in_req.valid && in_req.ready;
  assign head.valid   = (cnt_r != '0);
  assign head.item    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10: cnt_nxt = cnt_r + CNT_W'(1);
      2'b01: cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

/* rtl/sha1md_round.sv */
module sha1md_round (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1md_pkg::round_ctl_t rctl,
  output sha1md_pkg::round_sts_t rsts,
  output sha1md_pkg::word_t      chain [sha1md_pkg::DIGEST_WORDS]
);
  import sha1md_pkg::*;

  word_t      line_r  [LINE_WORDS];
  word_t      work_r  [DIGEST_WORDS];
  word_t      chain_r [DIGEST_WORDS];
  logic [6:0] rnd_r;

  word_t a, b, c, d, e;
  word_t w, x, new_w, line_in;
  word_t f, k, tmp;
  logic  shift_en;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  always_comb begin
    w     = line_r[0];
    x     = line_r[13] ^ line_r[8] ^ line_r[2] ^ line_r[0];
    new_w = rctl.sha1 ? {x[30:0], x[31]} : x;
    if (rnd_r < ROUND_B1) begin
      f = d ^ (b & (c ^ d));
      k = K0;
    end else if (rnd_r < ROUND_B2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd_r < ROUND_B3) begin
      f = (b & c) | (d & (b | c));
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    tmp      = {a[26:0], a[31:27]} + f + e + k + w;
    line_in  = rctl.step ? new_w : rctl.word;
    shift_en = rctl.step || rctl.push_word;
  end

  assign rsts.last = (rnd_r == ROUND_LAST);
  assign chain     = chain_r;

  // schedule window: line_r[0] is the word of the current round
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < LINE_WORDS - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[LINE_WORDS-1] <= line_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rctl.start) begin
      work_r <= chain_r;
    end else if (rctl.step) begin
      work_r[0] <= tmp;
      work_r[1] <= a;
      work_r[2] <= {b[1:0], b[31:2]};
      work_r[3] <= c;
      work_r[4] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (rctl.start) begin
      rnd_r <= '0;
    end else if (rctl.step) begin
      rnd_r <= rnd_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rctl.restart) begin
      chain_r <= INIT_H;
    end else if (rctl.fold) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

endmodule

/* rtl/sha1md_ctrl.sv */
module sha1md_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1md_pkg::head_t      head,
  output logic                   pop,
  sha1md_cfg_if.sink             cfg_wr,
  sha1md_out_if.source           out_rsp,
  output sha1md_pkg::round_ctl_t rctl,
  input  sha1md_pkg::round_sts_t rsts,
  input  sha1md_pkg::word_t      chain [sha1md_pkg::DIGEST_WORDS]
);
  import sha1md_pkg::*;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic        first_r, first_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        sha1_r;
  logic        out_valid_r, out_valid_nxt;
  word_t       out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic        byte_go;
  logic [7:0]  byte_val;
  state_t      byte_ret;
  logic [63:0] len_bits;
  logic [2:0]  len_sel;

  assign cfg_wr.ready        = 1'b1;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.digest_word = out_word_r;
  assign out_rsp.word_index  = out_idx_r;
  assign out_rsp.last        = out_last_r;

  assign len_bits = {cnt_r, 3'b000};
  assign len_sel  = 3'd7 - pos_r[2:0];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    rctl          = '0;
    rctl.sha1     = sha1_r;
    byte_go       = 1'b0;
    byte_val      = 8'h00;
    byte_ret      = ST_IDLE;

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.op == OP_ABSORB) begin
            byte_go  = 1'b1;
            byte_val = head.item.data;
            byte_ret = ST_IDLE;
            cnt_nxt  = cnt_r + 61'd1;
          end else begin
            state_nxt = ST_PAD;
            first_nxt = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (first_r) begin
          byte_go   = 1'b1;
          byte_val  = PAD_BYTE;
          byte_ret  = ST_PAD;
          first_nxt = 1'b0;
        end else if (pos_r == LEN_POS) begin
          state_nxt = ST_LEN;
        end else begin
          byte_go  = 1'b1;
          byte_val = 8'h00;
          byte_ret = ST_PAD;
        end
      end
      ST_LEN: begin
        byte_go  = 1'b1;
        byte_val = len_bits[{len_sel, 3'b000} +: 8];
        byte_ret = ST_EMIT;
      end
      ST_ROUND: begin
        rctl.step = 1'b1;
        if (rsts.last) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        rctl.fold = 1'b1;
        state_nxt = ret_r;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain[idx_r];
          out_idx_nxt   = idx_r;
          out_last_nxt  = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            idx_nxt      = '0;
            cnt_nxt      = '0;
            rctl.restart = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte packer, most significant byte first
    if (byte_go) begin
      rctl.word      = {acc_r, byte_val};
      rctl.push_word = (pos_r[1:0] == 2'd3);
      acc_nxt        = {acc_r[15:0], byte_val};
      pos_nxt        = pos_r + 6'd1;
      if (pos_r == LAST_POS) begin
        rctl.start = 1'b1;
        state_nxt  = ST_ROUND;
        ret_nxt    = byte_ret;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      sha1_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        sha1_r <= cfg_wr.rotate_schedule;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* rtl/sha1md_chk.sv */
`include "assert_macros.svh"

module sha1md_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last,
  input logic        cfg_ready
);

  // last marks word 4 and nothing else
  `SHA1MD_ASSERT_IMPL(a_last_idx, out_valid, (out_last == (out_word_index == 3'd4)))

  // digest words follow back to back in order
  `SHA1MD_ASSERT_NEXT(a_idx_seq, out_valid && out_ready && !out_last, out_valid && (out_word_index == $past(out_word_index) + 3'd1))

  // stalled digest word holds
  `SHA1MD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digest_word) && $stable(out_word_index))

  // config register always writable
  `SHA1MD_ASSERT_IMPL(a_cfg_rdy, 1'b1, cfg_ready)

endmodule

bind sha1_message_digest_core sha1md_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_digest_word(out_rsp.digest_word),
  .out_word_index (out_rsp.word_index),
  .out_last       (out_rsp.last),
  .cfg_ready      (cfg_wr.ready)
);
